// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL. Defining NO_ASSERTIONS
// removes every assertion from the build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, pre, post)

`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ----- src/nnt_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest-neighbour tour package
// Field widths, operation codes and controller states of the tour unit.
// ----------------------------------------------------------------------------
package nnt_pkg;

    localparam int OP_W   = 2;
    localparam int ID_W   = 6;
    localparam int DIST_W = 16;
    localparam int COST_W = 22;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_DIST = 2'd0,
        OP_APPEND     = 2'd1,
        OP_RUN        = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CUR_RD,
        S_CUR_EMIT,
        S_SCAN,
        S_PICK,
        S_RET_RD,
        S_RET_WAIT
    } t_state;

endpackage

// ----- src/nnt_in_if.sv -----
// ----------------------------------------------------------------------------
// Tour unit input channel
// Carries one command per transfer: a distance write, a member append or a run.
// ----------------------------------------------------------------------------
interface nnt_in_if;

    logic                      valid;
    logic                      ready;
    logic [nnt_pkg::OP_W-1:0]   opcode;
    logic [nnt_pkg::ID_W-1:0]   from_node;
    logic [nnt_pkg::ID_W-1:0]   to_node;
    logic [nnt_pkg::DIST_W-1:0] distance;
    logic [nnt_pkg::ID_W-1:0]   member_node;

    modport source (
        output valid, opcode, from_node, to_node, distance, member_node,
        input  ready
    );

    modport sink (
        input  valid, opcode, from_node, to_node, distance, member_node,
        output ready
    );

endinterface

// ----- src/nnt_out_if.sv -----
// ----------------------------------------------------------------------------
// Tour unit result channel
// Carries one visited node per transfer; the final transfer holds the cost.
// ----------------------------------------------------------------------------
interface nnt_out_if;

    logic                      valid;
    logic                      ready;
    logic [nnt_pkg::ID_W-1:0]   node_id;
    logic [nnt_pkg::COST_W-1:0] tour_cost;
    logic                      last;

    modport source (
        output valid, node_id, tour_cost, last,
        input  ready
    );

    modport sink (
        input  valid, node_id, tour_cost, last,
        output ready
    );

endinterface

// ----- src/nearest_neighbour_tour_unit.sv -----
// ----------------------------------------------------------------------------
// Nearest-neighbour tour unit
// Builds a greedy tour from depot node 0 over an appended list of cluster
// members, using a distance table held in on-chip memory.
// ----------------------------------------------------------------------------
// Distance writes and member appends are taken at one per cycle while the unit
// is idle. A run with m appended members holds off input until its last result
// has been loaded into the output register: each of the m moves scans all m+1
// list entries through the single read port of the member list, followed by
// the distance table read, one entry per cycle.
module nearest_neighbour_tour_unit #(
    parameter int NODE_COUNT  = 64,
    parameter int CLUSTER_MAX = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    nnt_in_if.sink    i_in,
    nnt_out_if.source o_res
);

    import nnt_pkg::*;

    `include "assert_macros.svh"

    localparam int MIW       = $clog2(CLUSTER_MAX + 1);
    localparam int TAB_DEPTH = NODE_COUNT * NODE_COUNT;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);
    localparam int FULL_W    = ID_W + TAB_AW;

    function automatic logic [TAB_AW-1:0] f_tab_addr(input logic [ID_W-1:0] row,
                                                     input logic [ID_W-1:0] col);
        logic [FULL_W-1:0] full;
        full = FULL_W'(row) * FULL_W'(NODE_COUNT) + FULL_W'(col);
        return full[TAB_AW-1:0];
    endfunction

    function automatic logic f_in_range(input logic [ID_W-1:0] row,
                                        input logic [ID_W-1:0] col);
        return (int'(row) < NODE_COUNT) && (int'(col) < NODE_COUNT);
    endfunction

    // Memories.
    logic [DIST_W-1:0] r_dist_mem [TAB_DEPTH];
    logic [ID_W-1:0]   r_member_mem [CLUSTER_MAX+1];
    logic [DIST_W-1:0] r_tab_rdata;
    logic              r_tab_oor;
    logic [ID_W-1:0]   r_mem_rdata;

    logic              w_tab_we;
    logic              w_tab_re;
    logic [ID_W-1:0]   w_tab_row;
    logic [ID_W-1:0]   w_tab_col;
    logic              w_mem_we;
    logic [ID_W-1:0]   w_mem_wdata;
    logic              w_mem_re;
    logic [MIW-1:0]    w_mem_raddr;

    // Control and datapath registers.
    t_state              r_state, n_state;
    logic [MIW-1:0]      r_count, n_count;
    logic [MIW-1:0]      r_cur, n_cur;
    logic [MIW-1:0]      r_steps, n_steps;
    logic [COST_W-1:0]   r_cost, n_cost;
    logic [CLUSTER_MAX:0] r_visited, n_visited;
    logic [ID_W-1:0]     r_cur_id, n_cur_id;
    logic [MIW-1:0]      r_j, n_j;
    logic                r_issue_done, n_issue_done;
    logic                r_p1_v, n_p1_v;
    logic [MIW-1:0]      r_p1_j, n_p1_j;
    logic                r_p1_vis, n_p1_vis;
    logic                r_p2_v, n_p2_v;
    logic [MIW-1:0]      r_p2_j, n_p2_j;
    logic                r_p2_vis, n_p2_vis;
    logic                r_p2_same, n_p2_same;
    logic                r_best_v, n_best_v;
    logic [MIW-1:0]      r_best, n_best;
    logic [DIST_W-1:0]   r_best_d, n_best_d;
    logic                r_fb_v, n_fb_v;
    logic [MIW-1:0]      r_fb, n_fb;
    logic                r_out_valid, n_out_valid;
    logic [ID_W-1:0]     r_out_node, n_out_node;
    logic [COST_W-1:0]   r_out_cost, n_out_cost;
    logic                r_out_last, n_out_last;

    logic                w_in_xfer;
    logic                w_out_free;
    logic                w_out_load;
    logic [DIST_W-1:0]   w_dist;
    logic [COST_W-1:0]   w_ret_sum;

    assign i_in.ready      = (r_state == S_IDLE);
    assign w_in_xfer       = i_in.valid && i_in.ready;
    assign w_out_free      = !r_out_valid || o_res.ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.node_id   = r_out_node;
    assign o_res.tour_cost = r_out_cost;
    assign o_res.last      = r_out_last;

    assign w_dist    = r_tab_oor ? '0 : r_tab_rdata;
    assign w_ret_sum = r_cost + COST_W'(w_dist);

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            r_dist_mem[f_tab_addr(i_in.from_node, i_in.to_node)] <= i_in.distance;
        end
        if (w_tab_re) begin
            r_tab_rdata <= r_dist_mem[f_tab_addr(w_tab_row, w_tab_col)];
            r_tab_oor   <= !f_in_range(w_tab_row, w_tab_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_member_mem[r_count] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_rdata <= r_member_mem[w_mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cur        <= '0;
            r_steps      <= '0;
            r_cost       <= '0;
            r_visited    <= '0;
            r_j          <= '0;
            r_issue_done <= 1'b1;
            r_p1_v       <= 1'b0;
            r_p2_v       <= 1'b0;
            r_best_v     <= 1'b0;
            r_fb_v       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_cur        <= n_cur;
            r_steps      <= n_steps;
            r_cost       <= n_cost;
            r_visited    <= n_visited;
            r_j          <= n_j;
            r_issue_done <= n_issue_done;
            r_p1_v       <= n_p1_v;
            r_p2_v       <= n_p2_v;
            r_best_v     <= n_best_v;
            r_fb_v       <= n_fb_v;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_id   <= n_cur_id;
        r_p1_j     <= n_p1_j;
        r_p1_vis   <= n_p1_vis;
        r_p2_j     <= n_p2_j;
        r_p2_vis   <= n_p2_vis;
        r_p2_same  <= n_p2_same;
        r_best     <= n_best;
        r_best_d   <= n_best_d;
        r_fb       <= n_fb;
        r_out_node <= n_out_node;
        r_out_cost <= n_out_cost;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_cost       = r_cost;
        n_visited    = r_visited;
        n_cur_id     = r_cur_id;
        n_j          = r_j;
        n_issue_done = r_issue_done;
        n_p1_v       = 1'b0;
        n_p1_j       = r_j;
        n_p1_vis     = r_visited[r_j];
        n_p2_v       = r_p1_v;
        n_p2_j       = r_p1_j;
        n_p2_vis     = r_p1_vis;
        n_p2_same    = (r_mem_rdata == r_cur_id);
        n_best_v     = r_best_v;
        n_best       = r_best;
        n_best_d     = r_best_d;
        n_fb_v       = r_fb_v;
        n_fb         = r_fb;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_node   = r_out_node;
        n_out_cost   = r_out_cost;
        n_out_last   = r_out_last;
        w_out_load   = 1'b0;
        w_tab_we     = 1'b0;
        w_tab_re     = 1'b0;
        w_tab_row    = r_cur_id;
        w_tab_col    = r_mem_rdata;
        w_mem_we     = 1'b0;
        w_mem_wdata  = i_in.member_node;
        w_mem_re     = 1'b0;
        w_mem_raddr  = r_j;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    unique case (t_opcode'(i_in.opcode))
                        OP_WRITE_DIST: begin
                            w_tab_we = f_in_range(i_in.from_node, i_in.to_node);
                        end
                        OP_APPEND: begin
                            if (r_count < MIW'(CLUSTER_MAX)) begin
                                w_mem_we = 1'b1;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        OP_RUN: begin
                            w_mem_we    = 1'b1;
                            w_mem_wdata = '0;
                            n_visited   = '0;
                            n_cur       = r_count;
                            n_cost      = '0;
                            n_steps     = '0;
                            n_state     = S_CUR_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CUR_RD: begin
                w_mem_re         = 1'b1;
                w_mem_raddr      = r_cur;
                n_visited[r_cur] = 1'b1;
                n_state          = S_CUR_EMIT;
            end
            S_CUR_EMIT: begin
                if (w_out_free) begin
                    w_out_load   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_node   = r_mem_rdata;
                    n_out_cost   = '0;
                    n_out_last   = 1'b0;
                    n_cur_id     = r_mem_rdata;
                    n_j          = '0;
                    n_issue_done = 1'b0;
                    n_best_v     = 1'b0;
                    n_fb_v       = 1'b0;
                    n_state      = (r_steps == r_count) ? S_RET_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_issue_done) begin
                    w_mem_re    = 1'b1;
                    w_mem_raddr = r_j;
                    n_p1_v      = 1'b1;
                    if (r_j == r_count) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
                if (r_p1_v) begin
                    w_tab_re  = 1'b1;
                    w_tab_row = r_cur_id;
                    w_tab_col = r_mem_rdata;
                end
                if (r_p2_v && !r_p2_vis) begin
                    if (!r_fb_v) begin
                        n_fb_v = 1'b1;
                        n_fb   = r_p2_j;
                    end
                    if (!r_p2_same && (!r_best_v || (w_dist < r_best_d))) begin
                        n_best_v = 1'b1;
                        n_best   = r_p2_j;
                        n_best_d = w_dist;
                    end
                end
                if (r_issue_done && !r_p1_v && !r_p2_v) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (r_best_v) begin
                    n_cur  = r_best;
                    n_cost = r_cost + COST_W'(r_best_d);
                end else begin
                    n_cur  = r_fb;
                end
                n_steps = r_steps + 1'b1;
                n_state = S_CUR_RD;
            end
            S_RET_RD: begin
                w_tab_re  = 1'b1;
                w_tab_row = r_cur_id;
                w_tab_col = '0;
                n_state   = S_RET_WAIT;
            end
            S_RET_WAIT: begin
                if (w_out_free) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_node  = '0;
                    n_out_cost  = w_ret_sum;
                    n_out_last  = 1'b1;
                    n_count     = '0;
                    n_visited   = '0;
                    n_cur       = '0;
                    n_cost      = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MIW'(CLUSTER_MAX))
    `ASSERT_IMPL(a_pick_has_fallback, i_clk, i_rst_n, r_state == S_PICK, r_fb_v)
    `ASSERT_IMPL(a_pick_before_end, i_clk, i_rst_n, r_state == S_PICK, r_steps < r_count)
    `ASSERT_IMPL(a_scan_no_result, i_clk, i_rst_n, r_state == S_SCAN, !w_out_load)
    `ASSERT_NEXT(a_run_end_clears, i_clk, i_rst_n,
                 (r_state == S_RET_WAIT) && w_out_load,
                 (r_count == '0) && (r_visited == '0) && r_out_last)

endmodule
